[sv/emfd_pkg.sv]
// ----------------------------------------------------------------------------
// emfd_pkg
// Shared types and constants of the energy meter frame decoder.
// ----------------------------------------------------------------------------
package emfd_pkg;

  localparam int ACC_W       = 80;  // product / quotient width
  localparam int DVS_W       = 64;  // multiplier / divisor width
  localparam int CNT_W       = 7;
  localparam int FRAME_BYTES = 24;
  localparam int FIELD_N     = 7;

  localparam logic [7:0]  HDR_A      = 8'h55;
  localparam logic [7:0]  HDR_B      = 8'hF2;
  localparam logic [7:0]  SYNC_BYTE  = 8'h5A;
  localparam logic [19:0] MILLION    = 20'd1000000;
  localparam logic [41:0] ENERGY_DIV = 42'd3600000000000;

  localparam logic [1:0] REG_VCOEFF = 2'd0;
  localparam logic [1:0] REG_CCOEFF = 2'd1;
  localparam logic [1:0] REG_MINV   = 2'd2;

  typedef enum logic [1:0] {
    ALU_MUL = 2'b01,
    ALU_DIV = 2'b10
  } alu_op_t;

  typedef struct packed {
    alu_op_t            op;
    logic [CNT_W-1:0]   count;
    logic [ACC_W-1:0]   a;
    logic [DVS_W-1:0]   b;
  } alu_cmd_t;

  typedef struct packed {
    logic [23:0] vp;
    logic [23:0] vr;
    logic [23:0] cp;
    logic [23:0] cr;
    logic [23:0] pp;
    logic [23:0] pr;
    logic [23:0] tail;   // bytes 20, 21, 22
    logic        f2;
    logic [15:0] ovf;
  } frame_t;

  typedef struct packed {
    logic        frame_ok;
    logic [19:0] voltage;
    logic [19:0] current;
    logic [19:0] power;
    logic [19:0] pf;
    logic [19:0] energy;
    logic        dz;
  } result_t;

endpackage

[sv/emfd_alu.sv]
// ----------------------------------------------------------------------------
// emfd_alu
// Shared shift-add multiplier and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module emfd_alu (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  emfd_pkg::alu_cmd_t      cmd,
  output logic                    done,
  output logic [emfd_pkg::ACC_W-1:0] res,
  output logic [emfd_pkg::DVS_W-1:0] rem
);
  import emfd_pkg::*;

  alu_cmd_t         cmd_q;
  logic [CNT_W-1:0] k;
  logic             run;
  logic [ACC_W-1:0] acc;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W:0]   trial;
  logic             ge;
  logic             bit_b;

  assign bit_b = cmd_q.b[k[5:0]];
  assign trial = {rem_q, cmd_q.a[k]};
  assign ge    = trial >= {1'b0, cmd_q.b};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && (k == '0);
      if (start) begin
        run <= 1'b1;
      end else if (run && (k == '0)) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cmd_q <= cmd;
      k     <= cmd.count - CNT_W'(1);
      acc   <= '0;
      rem_q <= '0;
    end else if (run) begin
      k <= k - CNT_W'(1);
      if (cmd_q.op == ALU_MUL) begin
        acc <= {acc[ACC_W-2:0], 1'b0} + (bit_b ? cmd_q.a : '0);
      end else begin
        acc   <= {acc[ACC_W-2:0], ge};
        rem_q <= ge ? DVS_W'(trial - {1'b0, cmd_q.b}) : trial[DVS_W-1:0];
      end
    end
  end

  assign res = acc;
  assign rem = rem_q;

  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !run)
    else $error("alu started while busy");
  a_done_after_run: assert property (@(posedge clk) disable iff (rst) done |-> $past(run))
    else $error("alu done without a run");
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
      (done && cmd_q.op == ALU_DIV && cmd_q.b != '0) |-> (rem_q < cmd_q.b))
    else $error("remainder not below divisor");

endmodule

[sv/emfd_seq.sv]
// ----------------------------------------------------------------------------
// emfd_seq
// Sequencer that walks the measurement arithmetic through the shared alu.
// ----------------------------------------------------------------------------
module emfd_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  emfd_pkg::frame_t  frm,
  input  logic [15:0]       vcoeff,
  input  logic [15:0]       ccoeff,
  input  logic [19:0]       minv,
  output logic              done,
  output emfd_pkg::result_t rslt
);
  import emfd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ISSUE = 3'b010,
    S_WAIT  = 3'b100
  } seq_state_t;

  typedef enum logic [4:0] {
    ST_VMUL  = 5'd0,
    ST_VDIV  = 5'd1,
    ST_IMUL  = 5'd2,
    ST_IDIV  = 5'd3,
    ST_PMUL  = 5'd4,
    ST_PDIV  = 5'd5,
    ST_VIMUL = 5'd6,
    ST_PFMUL = 5'd7,
    ST_PFDIV = 5'd8,
    ST_CMUL  = 5'd9,
    ST_EMUL  = 5'd10,
    ST_EDIV  = 5'd11,
    ST_VMOD  = 5'd12,
    ST_IMOD  = 5'd13,
    ST_PMOD  = 5'd14,
    ST_PFMOD = 5'd15,
    ST_EMOD  = 5'd16
  } step_t;

  seq_state_t       state;
  step_t            step;
  alu_cmd_t         cmd;
  logic             alu_start;
  logic             alu_done;
  logic [ACC_W-1:0] alu_res;
  logic [DVS_W-1:0] alu_rem;

  logic [ACC_W-1:0] t;
  logic [39:0]      v;
  logic [39:0]      i;
  logic [39:0]      p;
  logic [63:0]      vi;
  logic             pf_bad;
  logic [59:0]      pf;
  logic [31:0]      e;
  logic             dz;
  logic             pzero;
  logic [39:0]      vout;

  assign pzero     = frm.f2 && !frm.tail[20];
  assign vout      = (v < 40'(minv)) ? '0 : v;
  assign alu_start = (state == S_ISSUE);

  always_comb begin
    cmd.op    = ALU_DIV;
    cmd.count = CNT_W'(40);
    cmd.a     = t;
    cmd.b     = DVS_W'(MILLION);
    case (step)
      ST_VMUL: begin
        cmd.op = ALU_MUL; cmd.count = CNT_W'(16);
        cmd.a = ACC_W'(frm.vp); cmd.b = DVS_W'(vcoeff);
      end
      ST_VDIV:  cmd.b = DVS_W'(frm.vr);
      ST_IMUL: begin
        cmd.op = ALU_MUL; cmd.count = CNT_W'(16);
        cmd.a = ACC_W'(frm.cp); cmd.b = DVS_W'(ccoeff);
      end
      ST_IDIV:  cmd.b = DVS_W'(frm.cr);
      ST_PMUL: begin
        cmd.op = ALU_MUL; cmd.count = CNT_W'(16);
        cmd.a = ACC_W'(frm.pp); cmd.b = DVS_W'(vcoeff);
      end
      ST_PDIV:  cmd.b = DVS_W'(frm.pr);
      ST_VIMUL: begin
        cmd.op = ALU_MUL; cmd.count = CNT_W'(40);
        cmd.a = ACC_W'(v); cmd.b = DVS_W'(i);
      end
      ST_PFMUL: begin
        cmd.op = ALU_MUL; cmd.count = CNT_W'(20);
        cmd.a = ACC_W'(p); cmd.b = DVS_W'(MILLION);
      end
      ST_PFDIV: begin
        cmd.count = CNT_W'(60); cmd.b = vi;
      end
      ST_CMUL: begin
        cmd.op = ALU_MUL; cmd.count = CNT_W'(24);
        cmd.a = ACC_W'({frm.ovf, frm.tail[15:0]}); cmd.b = DVS_W'(frm.pp);
      end
      ST_EMUL: begin
        cmd.op = ALU_MUL; cmd.count = CNT_W'(16); cmd.b = DVS_W'(vcoeff);
      end
      ST_EDIV: begin
        cmd.count = CNT_W'(72); cmd.b = DVS_W'(ENERGY_DIV);
      end
      ST_VMOD:  cmd.a = ACC_W'(vout);
      ST_IMOD:  cmd.a = ACC_W'(i);
      ST_PMOD:  cmd.a = pzero ? '0 : ACC_W'(p);
      ST_PFMOD: begin
        cmd.count = CNT_W'(60); cmd.a = pzero ? '0 : ACC_W'(pf);
      end
      ST_EMOD: begin
        cmd.count = CNT_W'(32); cmd.a = ACC_W'(e);
      end
      default: cmd.count = CNT_W'(40);
    endcase
  end

  emfd_alu u_alu (
    .clk   (clk),
    .rst   (rst),
    .start (alu_start),
    .cmd   (cmd),
    .done  (alu_done),
    .res   (alu_res),
    .rem   (alu_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= ST_VMUL;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_ISSUE;
            step  <= ST_VMUL;
          end
        end
        S_ISSUE: state <= S_WAIT;
        S_WAIT: begin
          if (alu_done) begin
            if (step == ST_EMOD) begin
              state <= S_IDLE;
              done  <= 1'b1;
            end else begin
              state <= S_ISSUE;
              step  <= step_t'(step + 5'd1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // writeback of each step
  always_ff @(posedge clk) begin
    if (start && state == S_IDLE) begin
      dz <= 1'b0;
    end else if (state == S_WAIT && alu_done) begin
      case (step)
        ST_VDIV: begin
          v  <= (frm.vr == '0) ? '0 : alu_res[39:0];
          dz <= dz | (frm.vr == '0);
        end
        ST_IDIV: begin
          i  <= (frm.cr == '0) ? '0 : alu_res[39:0];
          dz <= dz | (frm.cr == '0);
        end
        ST_PDIV: begin
          p  <= (frm.pr == '0) ? '0 : alu_res[39:0];
          dz <= dz | (frm.pr == '0);
        end
        ST_VIMUL: begin
          vi     <= alu_res[63:0];
          pf_bad <= (v == '0) || (i == '0) || (alu_res[79:64] != '0);
          dz     <= dz | (v == '0) | (i == '0);
        end
        ST_PFDIV: pf <= pf_bad ? '0 : alu_res[59:0];
        ST_EDIV:  e  <= alu_res[31:0];
        ST_VMOD:  rslt.voltage <= alu_rem[19:0];
        ST_IMOD:  rslt.current <= alu_rem[19:0];
        ST_PMOD:  rslt.power   <= alu_rem[19:0];
        ST_PFMOD: rslt.pf      <= alu_rem[19:0];
        ST_EMOD: begin
          rslt.energy   <= alu_rem[19:0];
          rslt.dz       <= dz;
          rslt.frame_ok <= 1'b1;
        end
        default: t <= alu_res;
      endcase
    end
  end

endmodule

[sv/energy_meter_frame_decoder_top.sv]
// ----------------------------------------------------------------------------
// energy_meter_frame_decoder_top
// Meter frame hunt, checksum and capture, register port and result buffer.
// ----------------------------------------------------------------------------
//  channel | signals                            | direction
//  --------+------------------------------------+----------
//  in      | in_valid, in_ready, rx_byte        | request in
//  out     | out_valid, out_ready, result flds  | request out
//  apb     | psel, penable, pwrite, paddr, ...  | register port
//
//  non-final bytes take one cycle each, but none are taken while a result waits
//  a good frame runs after its checksum byte as 17 serial
//  multiply and divide steps through the one shared alu, one bit a cycle
//  a bad checksum skips the sequencer; its all-zero request waits in T_HOLD for the output register
//  in_ready is low from the checksum byte until the result enters the
//  output register; rst is synchronous and clears all control state
module energy_meter_frame_decoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        frame_ok,
  output logic [19:0] voltage_milli,
  output logic [19:0] current_milli,
  output logic [19:0] power_milli,
  output logic [19:0] power_factor_milli,
  output logic [19:0] energy_milli,
  output logic        divide_zero,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import emfd_pkg::*;

  typedef enum logic [2:0] {
    H_HUNT  = 3'b001,
    H_HDR   = 3'b010,
    H_FRAME = 3'b100
  } hunt_t;

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_CALC = 3'b010,
    T_HOLD = 3'b100
  } top_state_t;

  logic [15:0] vcoeff;
  logic [15:0] ccoeff;
  logic [19:0] minv;

  hunt_t       hunt;
  top_state_t  state;
  logic [4:0]  byte_index;
  logic [7:0]  check_sum;
  logic        header_f2;
  logic [23:0] fields [FIELD_N];
  logic [2:0]  fk;
  logic [1:0]  fph;
  logic        last_pulse;
  logic [15:0] ovf;
  logic        bad;

  logic        accept;
  logic        is_hdr;
  logic        last_byte;
  logic        seq_start;
  logic        seq_done;
  frame_t      frm;
  result_t     rslt;
  logic        load_out;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == T_IDLE);
  assign is_hdr    = (rx_byte == HDR_A) || (rx_byte == HDR_B);
  assign last_byte = (byte_index == 5'(FRAME_BYTES - 1));
  assign seq_start = accept && hunt == H_FRAME && last_byte && check_sum == rx_byte;

  // register port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      vcoeff <= 16'd3006;
      ccoeff <= 16'd1000;
      minv   <= 20'd2000;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_VCOEFF: vcoeff <= pwdata[15:0];
        REG_CCOEFF: ccoeff <= pwdata[15:0];
        REG_MINV:   minv   <= pwdata[19:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_VCOEFF: prdata = 32'(vcoeff);
      REG_CCOEFF: prdata = 32'(ccoeff);
      REG_MINV:   prdata = 32'(minv);
      default:    prdata = '0;
    endcase
  end

  // header hunt and frame capture
  always_ff @(posedge clk) begin
    if (rst) begin
      hunt       <= H_HUNT;
      byte_index <= '0;
      check_sum  <= '0;
      header_f2  <= 1'b0;
      fk         <= '0;
      fph        <= '0;
      last_pulse <= 1'b0;
      ovf        <= '0;
    end else if (accept) begin
      case (hunt)
        H_HDR: begin
          if (rx_byte == SYNC_BYTE) begin
            hunt       <= H_FRAME;
            byte_index <= 5'd2;
            check_sum  <= '0;
            fk         <= '0;
            fph        <= '0;
          end else if (is_hdr) begin
            header_f2 <= (rx_byte == HDR_B);
          end else begin
            hunt <= H_HUNT;
          end
        end
        H_FRAME: begin
          if (!last_byte) begin
            check_sum  <= check_sum + rx_byte;
            byte_index <= byte_index + 5'd1;
            if (fph == 2'd2) begin
              fph <= '0;
              fk  <= fk + 3'd1;
            end else begin
              fph <= fph + 2'd1;
            end
          end else begin
            hunt       <= H_HUNT;
            byte_index <= '0;
            check_sum  <= '0;
            // pulse overflow toggle, good frames only
            if (check_sum == rx_byte && fields[6][23] != last_pulse) begin
              last_pulse <= fields[6][23];
              ovf        <= ovf + 16'd1;
            end
          end
        end
        default: begin
          if (is_hdr) begin
            hunt      <= H_HDR;
            header_f2 <= (rx_byte == HDR_B);
          end else begin
            hunt <= H_HUNT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hunt == H_FRAME && !last_byte) begin
      fields[fk] <= {fields[fk][15:0], rx_byte};
    end
  end

  assign frm.vp   = fields[0];
  assign frm.vr   = fields[1];
  assign frm.cp   = fields[2];
  assign frm.cr   = fields[3];
  assign frm.pp   = fields[4];
  assign frm.pr   = fields[5];
  assign frm.tail = fields[6];
  assign frm.f2   = header_f2;
  assign frm.ovf  = ovf;

  emfd_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (seq_start),
    .frm    (frm),
    .vcoeff (vcoeff),
    .ccoeff (ccoeff),
    .minv   (minv),
    .done   (seq_done),
    .rslt   (rslt)
  );

  // result hand-off to the output register
  assign load_out = (state == T_HOLD) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      bad       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        T_IDLE: begin
          if (accept && hunt == H_FRAME && last_byte) begin
            bad   <= (check_sum != rx_byte);
            state <= (check_sum == rx_byte) ? T_CALC : T_HOLD;
          end
        end
        T_CALC: begin
          if (seq_done) begin
            state <= T_HOLD;
          end
        end
        T_HOLD: begin
          if (load_out) begin
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      frame_ok           <= bad ? 1'b0 : rslt.frame_ok;
      voltage_milli      <= bad ? '0 : rslt.voltage;
      current_milli      <= bad ? '0 : rslt.current;
      power_milli        <= bad ? '0 : rslt.power;
      power_factor_milli <= bad ? '0 : rslt.pf;
      energy_milli       <= bad ? '0 : rslt.energy;
      divide_zero        <= bad ? 1'b0 : rslt.dz;
    end
  end

  a_done_in_calc: assert property (@(posedge clk) disable iff (rst)
      seq_done |-> state == T_CALC)
    else $error("sequencer finished outside a calculation");
  a_end_blocks: assert property (@(posedge clk) disable iff (rst)
      (accept && hunt == H_FRAME && last_byte) |=> !in_ready)
    else $error("input still open after checksum byte");
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
      (out_valid && !frame_ok) |-> (voltage_milli == '0 && energy_milli == '0 && !divide_zero))
    else $error("bad frame request carries data");

endmodule
